### sv/kfps_pkg.sv
// types, constants and helpers shared by the keyed fifo with parity split
// no dependencies; the design files refer to this package by scoped names, the testbench files import it
`default_nettype none

package kfps_pkg;

  localparam int DEPTH = 4;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;

  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_POP     = 3'd1;
  localparam logic [2:0] CMD_EXTRACT = 3'd2;
  localparam logic [2:0] CMD_SPLIT   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] SEL_MAIN = 2'd0;
  localparam logic [1:0] SEL_EVEN = 2'd1;
  localparam logic [1:0] SEL_ODD  = 2'd2;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  typedef struct packed {
    logic [30:0] chassis;
    logic [30:0] plate;
    logic [11:0] year;
  } rec_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [30:0] chassis_in;
    logic [30:0] plate_in;
    logic [11:0] year_in;
    logic [1:0]  queue_select;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] chassis_out;
    logic [30:0] plate_out;
    logic [11:0] year_out;
    logic        record_valid;
    logic        last;
  } out_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    addr_t raddr;
    rec_t  wdata;
  } ram_req_t;

  function automatic addr_t addr_inc(addr_t a);
    addr_inc = (a == addr_t'(DEPTH - 1)) ? '0 : a + addr_t'(1);
  endfunction

  // ring position n places after a, n never above DEPTH
  function automatic addr_t addr_add(addr_t a, cnt_t n);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(n);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    addr_add = s[AW-1:0];
  endfunction

  function automatic out_t make_res(logic [1:0] st, rec_t r, logic rv, logic lst);
    out_t o;
    o.status       = st;
    o.chassis_out  = rv ? r.chassis : '0;
    o.plate_out    = rv ? r.plate : '0;
    o.year_out     = rv ? r.year : '0;
    o.record_valid = rv;
    o.last         = lst;
    make_res = o;
  endfunction

endpackage

`default_nettype wire

### sv/keyed_fifo_with_parity_split.sv
// top level: sequencer, three record stores and the result output register
// depends on kfps_pkg, kfps_ram and kfps_ctrl
//
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready | kfps_pkg::in_t
// out     | output    | out_valid/out_ready | kfps_pkg::out_t
//
// push, unused codes and any command that finds its queue empty go straight to their
// result; pop reads the head first; extract and split take one compare/route step per
// entry visited (up to DEPTH) through the single main store read port, and a read
// emits its records one by one.
// the output register lets a result wait while the sequencer moves on; a stalled
// out channel holds the sequencer at its next result. synchronous active-low reset
// clears state, counts, pointers and the output valid flag only.
`default_nettype none

module keyed_fifo_with_parity_split (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire kfps_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output kfps_pkg::out_t      out_data
);

  kfps_pkg::ram_req_t main_req, even_req, odd_req;
  kfps_pkg::rec_t     main_rdata, even_rdata, odd_rdata;
  kfps_pkg::out_t     res;
  logic               res_valid, res_ready;
  logic               out_valid_r;
  kfps_pkg::out_t     out_data_r;

  kfps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .main_req   (main_req),
    .even_req   (even_req),
    .odd_req    (odd_req),
    .main_rdata (main_rdata),
    .even_rdata (even_rdata),
    .odd_rdata  (odd_rdata)
  );

  kfps_ram u_main (.clk(clk), .req(main_req), .rdata(main_rdata));
  kfps_ram u_even (.clk(clk), .req(even_req), .rdata(even_rdata));
  kfps_ram u_odd  (.clk(clk), .req(odd_req),  .rdata(odd_rdata));

  // output beat register: refills in the cycle the previous beat leaves
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### sv/kfps_ram.sv
// record store of DEPTH entries, one write and one registered read per cycle
// depends on kfps_pkg for the record and request types
`default_nettype none

module kfps_ram (
  input  wire logic              clk,
  input  wire kfps_pkg::ram_req_t req,
  output kfps_pkg::rec_t          rdata
);

  kfps_pkg::rec_t mem [kfps_pkg::DEPTH];
  kfps_pkg::rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/kfps_ctrl.sv
// command sequencer: ring pointers, counts and the shared compare/route step
// depends on kfps_pkg; drives the three kfps_ram instances of the top level
`default_nettype none

module kfps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire kfps_pkg::in_t      in_data,
  output logic                    in_ready,
  output logic                    res_valid,
  output kfps_pkg::out_t          res,
  input  wire logic               res_ready,
  output kfps_pkg::ram_req_t      main_req,
  output kfps_pkg::ram_req_t      even_req,
  output kfps_pkg::ram_req_t      odd_req,
  input  wire kfps_pkg::rec_t     main_rdata,
  input  wire kfps_pkg::rec_t     even_rdata,
  input  wire kfps_pkg::rec_t     odd_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_EXT  = 3'd2;
  localparam logic [2:0] S_SPL  = 3'd3;
  localparam logic [2:0] S_RDO  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [2:0]      cmd_r, cmd_nxt;
  logic [30:0]     key_r, key_nxt;
  logic [1:0]      sel_r, sel_nxt;
  kfps_pkg::addr_t head_r, head_nxt;
  kfps_pkg::addr_t rptr_r, rptr_nxt;
  kfps_pkg::cnt_t  count_r, count_nxt;
  kfps_pkg::cnt_t  ecnt_r, ecnt_nxt;
  kfps_pkg::cnt_t  ocnt_r, ocnt_nxt;
  kfps_pkg::cnt_t  steps_r, steps_nxt;
  logic            blocked_r, blocked_nxt;
  kfps_pkg::out_t  res_r, res_nxt;

  always_comb begin
    kfps_pkg::cnt_t rcnt;
    kfps_pkg::rec_t rd;
    kfps_pkg::rec_t in_rec;
    rcnt        = '0;
    rd          = main_rdata;
    in_rec      = '{chassis: in_data.chassis_in, plate: in_data.plate_in,
                    year: in_data.year_in};
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    sel_nxt     = sel_r;
    head_nxt    = head_r;
    rptr_nxt    = rptr_r;
    count_nxt   = count_r;
    ecnt_nxt    = ecnt_r;
    ocnt_nxt    = ocnt_r;
    steps_nxt   = steps_r;
    blocked_nxt = blocked_r;
    res_nxt     = res_r;
    main_req    = '0;
    even_req    = '0;
    odd_req     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_data.cmd;
          key_nxt     = in_data.plate_in;
          sel_nxt     = in_data.queue_select;
          blocked_nxt = 1'b0;
          steps_nxt   = '0;
          rptr_nxt    = head_r;
          state_nxt   = S_EMIT;
          unique case (in_data.cmd)
            kfps_pkg::CMD_PUSH: begin
              if (count_r == kfps_pkg::cnt_t'(kfps_pkg::DEPTH)) begin
                res_nxt = kfps_pkg::make_res(kfps_pkg::ST_FULL, '0, 1'b0, 1'b1);
              end else begin
                main_req.we    = 1'b1;
                main_req.waddr = kfps_pkg::addr_add(head_r, count_r);
                main_req.wdata = in_rec;
                count_nxt      = count_r + kfps_pkg::cnt_t'(1);
                res_nxt = kfps_pkg::make_res(kfps_pkg::ST_OK, '0, 1'b0, 1'b1);
              end
            end
            kfps_pkg::CMD_POP: begin
              if (count_r == '0) begin
                res_nxt = kfps_pkg::make_res(kfps_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
              end else begin
                state_nxt = S_POP;
              end
            end
            kfps_pkg::CMD_EXTRACT: begin
              if (count_r == '0) begin
                res_nxt = kfps_pkg::make_res(kfps_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
              end else begin
                steps_nxt = count_r;
                state_nxt = S_EXT;
              end
            end
            kfps_pkg::CMD_SPLIT: begin
              if (count_r == '0) begin
                res_nxt = kfps_pkg::make_res(kfps_pkg::ST_OK, '0, 1'b0, 1'b1);
              end else begin
                steps_nxt = count_r;
                state_nxt = S_SPL;
              end
            end
            kfps_pkg::CMD_READ: begin
              unique case (in_data.queue_select)
                kfps_pkg::SEL_MAIN: rcnt = count_r;
                kfps_pkg::SEL_EVEN: begin
                  rcnt     = ecnt_r;
                  rptr_nxt = '0;
                end
                kfps_pkg::SEL_ODD: begin
                  rcnt     = ocnt_r;
                  rptr_nxt = '0;
                end
                default: rcnt = '0;
              endcase
              if (rcnt == '0) begin
                res_nxt = kfps_pkg::make_res(kfps_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
              end else begin
                steps_nxt = rcnt;
                state_nxt = S_RDO;
              end
            end
            default: begin
              res_nxt = kfps_pkg::make_res(kfps_pkg::ST_OK, '0, 1'b0, 1'b1);
            end
          endcase
        end
      end

      S_POP: begin
        res_nxt   = kfps_pkg::make_res(kfps_pkg::ST_OK, main_rdata, 1'b1, 1'b1);
        head_nxt  = kfps_pkg::addr_inc(head_r);
        count_nxt = count_r - kfps_pkg::cnt_t'(1);
        state_nxt = S_EMIT;
      end

      // rotate the head to the tail until the key shows up at the head or every entry was visited
      S_EXT: begin
        head_nxt = kfps_pkg::addr_inc(head_r);
        if (main_rdata.plate == key_r) begin
          res_nxt   = kfps_pkg::make_res(kfps_pkg::ST_OK, main_rdata, 1'b1, 1'b1);
          count_nxt = count_r - kfps_pkg::cnt_t'(1);
          steps_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          main_req.we    = 1'b1;
          main_req.waddr = kfps_pkg::addr_add(head_r, count_r);
          main_req.wdata = main_rdata;
          steps_nxt      = steps_r - kfps_pkg::cnt_t'(1);
          if (steps_r == kfps_pkg::cnt_t'(1)) begin
            res_nxt   = kfps_pkg::make_res(kfps_pkg::ST_NOTFOUND, '0, 1'b0, 1'b1);
            state_nxt = S_EMIT;
          end else begin
            rptr_nxt = kfps_pkg::addr_inc(head_r);
          end
        end
      end

      // route the head to its parity queue, or back to the main tail if full
      S_SPL: begin
        head_nxt  = kfps_pkg::addr_inc(head_r);
        steps_nxt = steps_r - kfps_pkg::cnt_t'(1);
        if (!main_rdata.plate[0] && ecnt_r != kfps_pkg::cnt_t'(kfps_pkg::DEPTH)) begin
          even_req.we    = 1'b1;
          even_req.waddr = ecnt_r[kfps_pkg::AW-1:0];
          even_req.wdata = main_rdata;
          ecnt_nxt       = ecnt_r + kfps_pkg::cnt_t'(1);
          count_nxt      = count_r - kfps_pkg::cnt_t'(1);
        end else if (main_rdata.plate[0] &&
                     ocnt_r != kfps_pkg::cnt_t'(kfps_pkg::DEPTH)) begin
          odd_req.we    = 1'b1;
          odd_req.waddr = ocnt_r[kfps_pkg::AW-1:0];
          odd_req.wdata = main_rdata;
          ocnt_nxt      = ocnt_r + kfps_pkg::cnt_t'(1);
          count_nxt     = count_r - kfps_pkg::cnt_t'(1);
        end else begin
          main_req.we    = 1'b1;
          main_req.waddr = kfps_pkg::addr_add(head_r, count_r);
          main_req.wdata = main_rdata;
          blocked_nxt    = 1'b1;
        end
        if (steps_r == kfps_pkg::cnt_t'(1)) begin
          res_nxt = kfps_pkg::make_res(blocked_nxt ? kfps_pkg::ST_FULL : kfps_pkg::ST_OK,
                                       '0, 1'b0, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          rptr_nxt = kfps_pkg::addr_inc(head_r);
        end
      end

      S_RDO: begin
        case (sel_r)
          kfps_pkg::SEL_EVEN: rd = even_rdata;
          kfps_pkg::SEL_ODD:  rd = odd_rdata;
          default:            rd = main_rdata;
        endcase
        res_nxt   = kfps_pkg::make_res(kfps_pkg::ST_OK, rd, 1'b1,
                                       steps_r == kfps_pkg::cnt_t'(1));
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (res_ready) begin
          if (cmd_r == kfps_pkg::CMD_READ && steps_r > kfps_pkg::cnt_t'(1)) begin
            steps_nxt = steps_r - kfps_pkg::cnt_t'(1);
            rptr_nxt  = kfps_pkg::addr_inc(rptr_r);
            state_nxt = S_RDO;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    main_req.raddr = rptr_nxt;
    even_req.raddr = rptr_nxt;
    odd_req.raddr  = rptr_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_EMIT);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
      ecnt_r  <= '0;
      ocnt_r  <= '0;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
      ecnt_r  <= ecnt_nxt;
      ocnt_r  <= ocnt_nxt;
      steps_r <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    sel_r     <= sel_nxt;
    blocked_r <= blocked_nxt;
    res_r     <= res_nxt;
  end

`ifndef SYNTH
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kfps_pkg::cnt_t'(kfps_pkg::DEPTH) &&
    ecnt_r <= kfps_pkg::cnt_t'(kfps_pkg::DEPTH) &&
    ocnt_r <= kfps_pkg::cnt_t'(kfps_pkg::DEPTH))
    else $error("queue count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is still in flight");

  a_extract_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXT |=> count_r <= $past(count_r))
    else $error("extract grew the main queue");

  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_r))
    else $error("pending result changed before hand-off");

  a_split_conserves: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPL |=>
      count_r + ecnt_r + ocnt_r == $past(count_r) + $past(ecnt_r) + $past(ocnt_r))
    else $error("split lost or invented a record");
`endif

endmodule

`default_nettype wire

### tb/kfps_checker.sv
// checker for the keyed fifo with parity split: watches both channels, keeps its
// own copy of the three queues and compares every result beat with the prediction
// depends on kfps_pkg for the beat types, command, status and selector codes
`timescale 1ns / 1ps

module kfps_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_ready,
  input  wire kfps_pkg::in_t  in_data,
  input  wire logic           out_valid,
  input  wire logic           out_ready,
  input  wire kfps_pkg::out_t out_data,
  output int                  fail_count,
  output int                  owed_count
);
  import kfps_pkg::*;

  rec_t main_q[$];
  rec_t even_q[$];
  rec_t odd_q[$];
  out_t owed_results[$];
  int   result_no;

  initial begin
    fail_count = 0;
    owed_count = 0;
    result_no  = 0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 40) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  task automatic owe(input logic [1:0] st, input rec_t r, input logic has_rec,
                     input logic fin);
    out_t o;
    o        = '0;
    o.status = st;
    if (has_rec) begin
      o.chassis_out  = r.chassis;
      o.plate_out    = r.plate;
      o.year_out     = r.year;
      o.record_valid = 1'b1;
    end
    o.last = fin;
    owed_results.push_back(o);
  endtask

  // works out the result beats one accepted command causes and updates the queues
  task automatic apply_command(input in_t c);
    rec_t r;
    rec_t hit;
    rec_t blank;
    rec_t keep[$];
    rec_t view[$];
    int   idx;
    logic blocked;
    blank     = '0;
    r.chassis = c.chassis_in;
    r.plate   = c.plate_in;
    r.year    = c.year_in;
    case (c.cmd)
      CMD_PUSH: begin
        if (main_q.size() >= DEPTH) begin
          owe(ST_FULL, blank, 1'b0, 1'b1);
        end else begin
          main_q.push_back(r);
          owe(ST_OK, blank, 1'b0, 1'b1);
        end
      end
      CMD_POP: begin
        if (main_q.size() == 0) begin
          owe(ST_EMPTY, blank, 1'b0, 1'b1);
        end else begin
          hit = main_q.pop_front();
          owe(ST_OK, hit, 1'b1, 1'b1);
        end
      end
      CMD_EXTRACT: begin
        if (main_q.size() == 0) begin
          owe(ST_EMPTY, blank, 1'b0, 1'b1);
        end else begin
          idx = -1;
          foreach (main_q[i]) begin
            if (idx < 0 && main_q[i].plate == r.plate) idx = i;
          end
          if (idx < 0) begin
            owe(ST_NOTFOUND, blank, 1'b0, 1'b1);
          end else begin
            // rotate: records after the match first, then those before it
            hit = main_q[idx];
            for (int j = idx + 1; j < main_q.size(); j++) keep.push_back(main_q[j]);
            for (int j = 0; j < idx; j++) keep.push_back(main_q[j]);
            main_q = keep;
            owe(ST_OK, hit, 1'b1, 1'b1);
          end
        end
      end
      CMD_SPLIT: begin
        blocked = 1'b0;
        foreach (main_q[i]) begin
          if (!main_q[i].plate[0]) begin
            if (even_q.size() < DEPTH) even_q.push_back(main_q[i]);
            else begin
              keep.push_back(main_q[i]);
              blocked = 1'b1;
            end
          end else begin
            if (odd_q.size() < DEPTH) odd_q.push_back(main_q[i]);
            else begin
              keep.push_back(main_q[i]);
              blocked = 1'b1;
            end
          end
        end
        main_q = keep;
        owe(blocked ? ST_FULL : ST_OK, blank, 1'b0, 1'b1);
      end
      CMD_READ: begin
        case (c.queue_select)
          SEL_MAIN: view = main_q;
          SEL_EVEN: view = even_q;
          SEL_ODD:  view = odd_q;
          default:  view.delete();
        endcase
        if (view.size() == 0) begin
          owe(ST_EMPTY, blank, 1'b0, 1'b1);
        end else begin
          foreach (view[i]) owe(ST_OK, view[i], 1'b1, i == view.size() - 1);
        end
      end
      default: owe(ST_OK, blank, 1'b0, 1'b1);
    endcase
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    result_no++;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing owed", result_no));
      return;
    end
    want = owed_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("result %0d status %0d, want %0d",
                                result_no, got.status, want.status));
    if (got.chassis_out !== want.chassis_out)
      report_mismatch($sformatf("result %0d chassis %0h, want %0h",
                                result_no, got.chassis_out, want.chassis_out));
    if (got.plate_out !== want.plate_out)
      report_mismatch($sformatf("result %0d plate %0h, want %0h",
                                result_no, got.plate_out, want.plate_out));
    if (got.year_out !== want.year_out)
      report_mismatch($sformatf("result %0d year %0h, want %0h",
                                result_no, got.year_out, want.year_out));
    if (got.record_valid !== want.record_valid)
      report_mismatch($sformatf("result %0d record_valid %b, want %b",
                                result_no, got.record_valid, want.record_valid));
    if (got.last !== want.last)
      report_mismatch($sformatf("result %0d last %b, want %b",
                                result_no, got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      main_q.delete();
      even_q.delete();
      odd_q.delete();
      owed_results.delete();
    end else begin
      // a result beat can never belong to the command accepted on the same edge
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) apply_command(in_data);
    end
    owed_count = owed_results.size();
  end

endmodule

### tb/keyed_fifo_with_parity_split_tb.sv
// testbench top for keyed_fifo_with_parity_split: clock, reset, command stimulus
// with random gaps and result back-pressure, final verdict
// depends on kfps_pkg, the block itself and kfps_checker
`timescale 1ns / 1ps

module keyed_fifo_with_parity_split_tb;
  import kfps_pkg::*;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   owed_count;

  logic        calm       = 1'b0;
  int          stall_left = 0;
  logic [30:0] recent_plates[$];

  keyed_fifo_with_parity_split dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  kfps_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #600000;
    $display("TB_ERROR");
    $finish;
  end

  // result back-pressure: mostly ready, short stalls, the odd long one
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm) begin
        if (r < 15) stall_left <= $urandom_range(1, 3);
        else if (r < 17) stall_left <= $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_t make_beat(logic [2:0] op, logic [30:0] chassis,
                                    logic [30:0] plate, logic [11:0] year,
                                    logic [1:0] sel);
    in_t b;
    b.cmd          = op;
    b.chassis_in   = chassis;
    b.plate_in     = plate;
    b.year_in      = year;
    b.queue_select = sel;
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input in_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    if (beat.cmd == CMD_PUSH) begin
      recent_plates.push_back(beat.plate_in);
      if (recent_plates.size() > 8) void'(recent_plates.pop_front());
    end
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [30:0] pick_plate();
    // small plates give duplicates and collisions for extract
    if ($urandom_range(0, 1) == 0) return 31'($urandom_range(0, 15));
    return 31'($urandom);
  endfunction

  function automatic in_t random_beat();
    in_t b;
    int  pick;
    b.chassis_in   = 31'($urandom);
    b.plate_in     = pick_plate();
    b.year_in      = 12'($urandom);
    b.queue_select = 2'($urandom_range(0, 3));
    pick           = $urandom_range(0, 99);
    if (pick < 35) b.cmd = CMD_PUSH;
    else if (pick < 50) b.cmd = CMD_POP;
    else if (pick < 70) begin
      b.cmd = CMD_EXTRACT;
      if (recent_plates.size() > 0 && $urandom_range(0, 3) != 0)
        b.plate_in = recent_plates[$urandom_range(0, recent_plates.size() - 1)];
    end
    else if (pick < 78) b.cmd = CMD_SPLIT;
    else if (pick < 95) b.cmd = CMD_READ;
    else b.cmd = CMD_READ + 3'($urandom_range(1, 3));  // unused codes
    return b;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queues everywhere
    send_beat(make_beat(CMD_READ, '0, '0, '0, SEL_MAIN));
    send_beat(make_beat(CMD_READ, '0, '0, '0, SEL_EVEN));
    send_beat(make_beat(CMD_READ, '0, '0, '0, SEL_ODD));
    send_beat(make_beat(CMD_READ, '1, '1, '1, 2'd3));
    send_beat(make_beat(CMD_POP, '0, '0, '0, SEL_MAIN));
    send_beat(make_beat(CMD_EXTRACT, '0, 31'd5, '0, SEL_MAIN));
    send_beat(make_beat(CMD_SPLIT, '0, '0, '0, SEL_MAIN));
    // fill to capacity with field extremes, then overflow
    send_beat(make_beat(CMD_PUSH, '1, '1, '1, SEL_MAIN));
    send_beat(make_beat(CMD_PUSH, '0, '0, '0, SEL_MAIN));
    send_beat(make_beat(CMD_PUSH, 31'h2aaa_5555, 31'd1234, 12'h5a5, SEL_MAIN));
    send_beat(make_beat(CMD_PUSH, 31'h5555_2aaa, 31'd77, 12'ha5a, SEL_MAIN));
    send_beat(make_beat(CMD_PUSH, 31'd9, 31'd11, 12'd1, SEL_MAIN));
    send_beat(make_beat(CMD_READ, '0, '0, '0, SEL_MAIN));
    send_beat(make_beat(CMD_EXTRACT, '0, 31'd999, '0, SEL_MAIN));
    // match in the middle rotates the queue
    send_beat(make_beat(CMD_EXTRACT, '0, 31'd1234, '0, SEL_MAIN));
    send_beat(make_beat(CMD_POP, '0, '0, '0, SEL_MAIN));
    send_beat(make_beat(CMD_SPLIT, '0, '0, '0, SEL_MAIN));
    send_beat(make_beat(CMD_READ, '0, '0, '0, SEL_EVEN));
    send_beat(make_beat(CMD_READ, '0, '0, '0, SEL_ODD));
    send_beat(make_beat(CMD_READ + 3'd1, '1, '1, '1, 2'd3));
    send_beat(make_beat(CMD_READ + 3'd3, '0, '0, '0, SEL_MAIN));
    // overfill the even queue so the split leaves one record behind
    for (int i = 1; i <= 4; i++)
      send_beat(make_beat(CMD_PUSH, 31'(i), 31'(2 * i), 12'(i), SEL_MAIN));
    send_beat(make_beat(CMD_SPLIT, '0, '0, '0, SEL_MAIN));
    send_beat(make_beat(CMD_READ, '0, '0, '0, SEL_MAIN));

    for (int n = 0; n < 93; n++) begin
      if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
      send_beat(random_beat());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    wait (owed_count == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && owed_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/kfps_pkg.sv
sv/kfps_ram.sv
sv/kfps_ctrl.sv
sv/keyed_fifo_with_parity_split.sv
tb/kfps_checker.sv
tb/keyed_fifo_with_parity_split_tb.sv
